### src/sacos_pkg.sv
`default_nettype none

package sacos_pkg;

	// fixed field widths
	localparam int CMD_W  = 2;
	localparam int IDX_W  = 12;
	localparam int CHAR_W = 8;
	localparam int SIZE_W = 13;
	localparam int SIDX_W = 14;
	localparam int ENT_W  = 14;

	typedef logic [CMD_W-1:0]         cmdcode_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CHAR_W-1:0]        char_t;
	typedef logic [SIZE_W-1:0]        size_t;
	typedef logic signed [SIDX_W-1:0] sidx_t;
	typedef logic [1:0]               phase_t;

	// input commands
	localparam cmdcode_t CMD_WR_TEXT = 2'd0;
	localparam cmdcode_t CMD_WR_SA   = 2'd1;
	localparam cmdcode_t CMD_QUERY   = 2'd2;

	// search phases: locate any match, left edge, right edge
	localparam phase_t PH_A = 2'd0;
	localparam phase_t PH_B = 2'd1;
	localparam phase_t PH_C = 2'd2;

	localparam sidx_t FIRST_NONE = 14'h3FFF;

	typedef struct packed {
		cmdcode_t command;
		idx_t     write_index;
		char_t    text_char;
		idx_t     suffix_start;
		char_t    query_char;
		idx_t     query_offset;
		idx_t     range_base;
		size_t    range_size;
	} item_t;

	typedef struct packed {
		logic   wr_text;
		logic   wr_sa;
		logic   load;
		logic   step;
		logic   start_c;
		logic   emit;
		phase_t phase;
	} ctl_cmd_t;

	typedef struct packed {
		logic sz_zero;
		logic eq;
		logic special;
	} ctl_stat_t;

endpackage

`default_nettype wire

### src/sacos_ifs.sv
`default_nettype none

interface sacos_in_if;
	import sacos_pkg::*;

	logic     valid;
	logic     ready;
	cmdcode_t command;
	idx_t     write_index;
	char_t    text_char;
	idx_t     suffix_start;
	char_t    query_char;
	idx_t     query_offset;
	idx_t     range_base;
	size_t    range_size;

	modport source (
		output valid, command, write_index, text_char, suffix_start,
		       query_char, query_offset, range_base, range_size,
		input  ready
	);
	modport sink (
		input  valid, command, write_index, text_char, suffix_start,
		       query_char, query_offset, range_base, range_size,
		output ready
	);
endinterface

interface sacos_out_if;
	import sacos_pkg::*;

	logic  valid;
	logic  ready;
	size_t match_count;
	sidx_t first_index;
	logic  range_error;

	modport source (
		output valid, match_count, first_index, range_error,
		input  ready
	);
	modport sink (
		input  valid, match_count, first_index, range_error,
		output ready
	);
endinterface

`default_nettype wire

### src/sacos_ram.sv
`default_nettype none

module sacos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire

### src/sacos_dp.sv
`default_nettype none

module sacos_dp #(
	parameter int MAX_LEN = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire sacos_pkg::size_t      cfg_wdata,
	input  wire sacos_pkg::item_t      item,
	input  wire sacos_pkg::ctl_cmd_t   cmd,
	output sacos_pkg::ctl_stat_t       st,
	output sacos_pkg::size_t           match_count,
	output sacos_pkg::sidx_t           first_index,
	output logic                       range_error
);
	import sacos_pkg::*;

	localparam int          AW        = $clog2(MAX_LEN);
	localparam logic [31:0] MAX_LEN_W = 32'(MAX_LEN);

	size_t text_length_q;
	size_t tlen_q, tlen_in;
	size_t pos_q, sz_q, rsz_q, kpos_q, jpos_q;
	size_t half, p, pos_right, sz_right;
	char_t qchar_q;
	idx_t  qoff_q, base_q;
	logic  err_q, empty_q, found_q;
	logic  e_out_q, key_out_q;
	logic  [ENT_W-1:0] e;
	logic  [AW-1:0] sa_raddr, tx_raddr, waddr;
	logic  wr_ok;
	idx_t  sa_rdata;
	char_t tx_rdata;
	logic  key_lt, key_eq, go_right;
	size_t count_q;
	sidx_t first_q;
	logic  rerr_q;

	// probe entry and key position
	assign half      = sz_q >> 1;
	assign e         = ENT_W'(base_q) + ENT_W'(pos_q) + ENT_W'(half);
	assign sa_raddr  = AW'(e);
	assign p         = SIZE_W'(sa_rdata) + SIZE_W'(qoff_q);
	assign tx_raddr  = AW'(p);
	assign pos_right = pos_q + half + SIZE_W'(1);
	assign sz_right  = sz_q - half - SIZE_W'(1);

	assign wr_ok = 32'(item.write_index) < MAX_LEN_W;
	assign waddr = AW'(item.write_index);

	assign tlen_in = (32'(text_length_q) > MAX_LEN_W) ? SIZE_W'(MAX_LEN) : text_length_q;

	// past the text end ranks below every character
	assign key_lt = key_out_q || (tx_rdata < qchar_q);
	assign key_eq = !key_out_q && (tx_rdata == qchar_q);

	always_comb begin
		case (cmd.phase)
			PH_A:    go_right = key_lt;
			PH_B:    go_right = key_lt;
			PH_C:    go_right = key_lt || key_eq;
			default: go_right = 1'b0;
		endcase
	end

	sacos_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_sa_ram (
		.clk   (clk),
		.we    (cmd.wr_sa && wr_ok),
		.waddr (waddr),
		.wdata (item.suffix_start),
		.raddr (sa_raddr),
		.rdata (sa_rdata)
	);

	sacos_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_tx_ram (
		.clk   (clk),
		.we    (cmd.wr_text && wr_ok),
		.waddr (waddr),
		.wdata (item.text_char),
		.raddr (tx_raddr),
		.rdata (tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_length_q <= '0;
		end else if (cfg_we) begin
			text_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		e_out_q   <= 32'(e) >= MAX_LEN_W;
		key_out_q <= e_out_q || (p >= tlen_q);

		if (cmd.load) begin
			qchar_q <= item.query_char;
			qoff_q  <= item.query_offset;
			base_q  <= item.range_base;
			tlen_q  <= tlen_in;
			err_q   <= (32'(item.range_base) + 32'(item.range_size)) > MAX_LEN_W;
			empty_q <= (tlen_in == '0) || (item.range_size == '0);
			pos_q   <= '0;
			sz_q    <= item.range_size;
			found_q <= 1'b0;
		end else if (cmd.start_c) begin
			jpos_q <= pos_q;
			pos_q  <= kpos_q;
			sz_q   <= rsz_q;
		end else if (cmd.step) begin
			if (cmd.phase == PH_A && key_eq) begin
				// split into left-edge and right-edge searches
				found_q <= 1'b1;
				jpos_q  <= pos_q;
				kpos_q  <= pos_right;
				rsz_q   <= sz_right;
				sz_q    <= half;
			end else if (go_right) begin
				pos_q <= pos_right;
				sz_q  <= sz_right;
			end else begin
				sz_q <= half;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (err_q || empty_q) begin
				count_q <= '0;
				first_q <= FIRST_NONE;
				rerr_q  <= err_q;
			end else if (found_q) begin
				count_q <= pos_q - jpos_q;
				first_q <= SIDX_W'(jpos_q);
				rerr_q  <= 1'b0;
			end else begin
				count_q <= '0;
				first_q <= SIDX_W'(pos_q);
				rerr_q  <= 1'b0;
			end
		end
	end

	assign st.sz_zero = (sz_q == '0);
	assign st.eq      = key_eq;
	assign st.special = err_q || empty_q;

	assign match_count = count_q;
	assign first_index = first_q;
	assign range_error = rerr_q;
endmodule

`default_nettype wire

### src/sacos_ctrl.sv
`default_nettype none

module sacos_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire sacos_pkg::cmdcode_t in_command,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output sacos_pkg::ctl_cmd_t      cmd,
	input  wire sacos_pkg::ctl_stat_t st
);
	import sacos_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_SA    = 3'd2;
	localparam logic [2:0] S_TX    = 3'd3;
	localparam logic [2:0] S_CMP   = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q, state_d;
	phase_t     ph_q, ph_d;
	logic       out_valid_q, out_valid_d;
	logic       accept, slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d     = state_q;
		ph_d        = ph_q;
		cmd         = '0;
		cmd.phase   = ph_q;
		out_valid_d = out_valid_q && !out_ready;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_command)
						CMD_WR_TEXT: cmd.wr_text = 1'b1;
						CMD_WR_SA:   cmd.wr_sa = 1'b1;
						CMD_QUERY: begin
							cmd.load = 1'b1;
							state_d  = S_CHECK;
						end
						default: ;
					endcase
				end
			end
			S_CHECK: begin
				ph_d    = PH_A;
				state_d = st.special ? S_DONE : S_SA;
			end
			S_SA: begin
				if (st.sz_zero) begin
					case (ph_q)
						PH_B: begin
							cmd.start_c = 1'b1;
							ph_d        = PH_C;
						end
						default: state_d = S_DONE;
					endcase
				end else begin
					state_d = S_TX;
				end
			end
			S_TX: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.step = 1'b1;
				if (ph_q == PH_A && st.eq) begin
					ph_d = PH_B;
				end
				state_d = S_SA;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.emit    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= PH_A;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ph_q        <= ph_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;
endmodule

`default_nettype wire

### src/suffix_array_char_offset_search_core.sv
`default_nettype none

// write transactions: accepted back to back
// query: an empty range or a range error goes straight to the result; else each probe is
//   a suffix ram read, then a text ram read, then a compare; a match splits the search in two
// at most 24 probes for a 4096-entry range; one query in flight at a time,
//   the next transaction is taken in the cycle after the result is registered
// the result sits in an output register, so the next transaction is taken while it waits
// reset: arst_n clears the controller, output valid and text_length; stores are not cleared
module suffix_array_char_offset_search_core #(
	parameter int MAX_LEN = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire sacos_pkg::size_t cfg_wdata,
	sacos_in_if.sink              in_ch,
	sacos_out_if.source           out_ch
);
	import sacos_pkg::*;

	item_t     item;
	ctl_cmd_t  cmd;
	ctl_stat_t st;

	// gather the input transaction payload
	assign item.command      = in_ch.command;
	assign item.write_index  = in_ch.write_index;
	assign item.text_char    = in_ch.text_char;
	assign item.suffix_start = in_ch.suffix_start;
	assign item.query_char   = in_ch.query_char;
	assign item.query_offset = in_ch.query_offset;
	assign item.range_base   = in_ch.range_base;
	assign item.range_size   = in_ch.range_size;

	// sequencer: store writes, range check, then up to three chained binary searches
	sacos_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_command (in_ch.command),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.cmd        (cmd),
		.st         (st)
	);

	// stores, search cursor and result register
	sacos_dp #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.item        (item),
		.cmd         (cmd),
		.st          (st),
		.match_count (out_ch.match_count),
		.first_index (out_ch.first_index),
		.range_error (out_ch.range_error)
	);
endmodule

`default_nettype wire
